// ===== rtl/hpd_pkg.sv =====
// Package for the helicoid point and derivative evaluator.
// Types, fixed-point constants and divider tables shared by every rtl file.
package hpd_pkg;

    localparam int ORDER_BITS = 4;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;
    localparam int SINQ_LAT   = 19;
    localparam int NSTEP      = 5;
    localparam int CFG_IDX_W  = 3;

    localparam logic [30:0]        ONE_Q30        = 31'h4000_0000;
    localparam logic [30:0]        HALF_PI_Q30    = 31'd1686629713;
    localparam logic signed [29:0] INV_TWO_PI_Q30 = 30'sd170891319;
    localparam logic [22:0]        QUARTER_TURN   = 23'h40_0000;
    localparam logic signed [63:0] OUT_MAX        = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] OUT_MIN        = -64'sh0000_8000_0000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_AXIS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_AXIS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Z_AXIS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH    = 3'd6;

    typedef enum logic [2:0] {
        MODE_POINT,
        MODE_DU1,
        MODE_DUN,
        MODE_DV1,
        MODE_ZERO
    } t_mode;

    typedef struct packed {
        logic [2:0][31:0]  origin;
        logic [2:0][47:0]  axis;
        logic signed [31:0] pitch;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
        t_mode              mode;
        logic [22:0]        rs;
        logic [22:0]        rc;
        logic               neg_s;
        logic               neg_c;
    } t_fitem;

    typedef struct packed {
        logic signed [31:0] v;
        t_mode              mode;
        logic               neg_s;
        logic               neg_c;
        logic signed [47:0] cz;
    } t_side;

    // series divisors, innermost first
    function automatic logic [6:0] step_div(input int k);
        logic [6:0] d;
        case (k)
            0:       d = 7'd110;
            1:       d = 7'd72;
            2:       d = 7'd42;
            3:       d = 7'd20;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    // floor(2^34 / divisor)
    function automatic logic [31:0] step_mul(input int k);
        logic [31:0] m;
        case (k)
            0:       m = 32'd156180628;
            1:       m = 32'd238609294;
            2:       m = 32'd409044504;
            3:       m = 32'd858993459;
            default: m = 32'd2863311530;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/hpd_if.sv =====
// Handshake channel interfaces for the helicoid evaluator.
// Depends on hpd_pkg for the order and config index field widths.
interface hpd_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [31:0]               angle_turns;
    logic signed [31:0]               radius_param;
    logic [hpd_pkg::ORDER_BITS-1:0]   order_u;
    logic [hpd_pkg::ORDER_BITS-1:0]   order_v;
    modport source (output valid, angle_turns, radius_param, order_u, order_v,
                    input ready);
    modport sink   (input valid, angle_turns, radius_param, order_u, order_v,
                    output ready);
endinterface

interface hpd_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] res_x;
    logic signed [47:0] res_y;
    logic signed [47:0] res_z;
    logic               saturated;
    modport source (output valid, res_x, res_y, res_z, saturated, input ready);
    modport sink   (input valid, res_x, res_y, res_z, saturated, output ready);
endinterface

interface hpd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [hpd_pkg::CFG_IDX_W-1:0]   index;
    logic [47:0]                     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/helicoid_point_and_derivative.sv =====
// Helicoid point and derivative evaluator, top level with configuration registers.
// Throughput: one item per cycle; set by the 19-stage sin/cos series pipeline and
// the 6-stage product, sum and clip pipeline, all stalling together on output back-pressure.
// Reset (synchronous, active low) empties queue and pipeline and loads register defaults.
// Depends on hpd_pkg, hpd_if, hpd_front, hpd_queue, hpd_back.
module helicoid_point_and_derivative (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hpd_in_if.sink      i_in,
    hpd_out_if.source   o_out,
    hpd_cfg_if.sink     i_cfg
);
    hpd_pkg::t_cfg   r_cfg;
    hpd_pkg::t_fitem w_fitem;
    hpd_pkg::t_fitem w_head;
    logic            w_full;
    logic            w_push;
    logic            w_head_valid;
    logic            w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin <= '0;
            r_cfg.axis[0] <= 48'h0000_0000_8000;
            r_cfg.axis[1] <= 48'h0000_8000_0000;
            r_cfg.axis[2] <= 48'h8000_0000_0000;
            r_cfg.pitch   <= 32'sd65536;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                hpd_pkg::REG_ORIGIN_X: r_cfg.origin[0] <= i_cfg.data[31:0];
                hpd_pkg::REG_ORIGIN_Y: r_cfg.origin[1] <= i_cfg.data[31:0];
                hpd_pkg::REG_ORIGIN_Z: r_cfg.origin[2] <= i_cfg.data[31:0];
                hpd_pkg::REG_X_AXIS:   r_cfg.axis[0]   <= i_cfg.data;
                hpd_pkg::REG_Y_AXIS:   r_cfg.axis[1]   <= i_cfg.data;
                hpd_pkg::REG_Z_AXIS:   r_cfg.axis[2]   <= i_cfg.data;
                hpd_pkg::REG_PITCH:    r_cfg.pitch     <= $signed(i_cfg.data[31:0]);
                default: ;
            endcase
        end
    end

    assign i_in.ready = !w_full;
    assign w_push     = i_in.valid && !w_full;

    hpd_front u_front (
        .i_angle_turns (i_in.angle_turns),
        .i_radius_param(i_in.radius_param),
        .i_order_u     (i_in.order_u),
        .i_order_v     (i_in.order_v),
        .o_item        (w_fitem)
    );

    hpd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_item (w_fitem),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_valid(w_head_valid),
        .o_item (w_head)
    );

    hpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head_valid(w_head_valid),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out       (o_out)
    );
endmodule

// ===== rtl/hpd_front.sv =====
// Front end: classifies an item by derivative order and derives sin/cos phases.
// Depends on hpd_pkg.
module hpd_front (
    input  logic signed [31:0]             i_angle_turns,
    input  logic signed [31:0]             i_radius_param,
    input  logic [hpd_pkg::ORDER_BITS-1:0] i_order_u,
    input  logic [hpd_pkg::ORDER_BITS-1:0] i_order_v,
    output hpd_pkg::t_fitem                o_item
);
    logic [23:0] w_ps;
    logic [23:0] w_pc;

    always_comb begin
        w_ps = i_angle_turns[23:0] + {i_order_u[1:0], 22'd0};
        w_pc = w_ps + 24'h40_0000;

        o_item.u     = i_angle_turns;
        o_item.v     = i_radius_param;
        o_item.neg_s = w_ps[23];
        o_item.neg_c = w_pc[23];
        o_item.rs    = w_ps[22] ? (hpd_pkg::QUARTER_TURN - {1'b0, w_ps[21:0]})
                                : {1'b0, w_ps[21:0]};
        o_item.rc    = w_pc[22] ? (hpd_pkg::QUARTER_TURN - {1'b0, w_pc[21:0]})
                                : {1'b0, w_pc[21:0]};

        if (i_order_v >= hpd_pkg::ORDER_BITS'(2)) begin
            o_item.mode = hpd_pkg::MODE_ZERO;
        end else if (i_order_v == hpd_pkg::ORDER_BITS'(1)) begin
            o_item.mode = hpd_pkg::MODE_DV1;
        end else if (i_order_u == '0) begin
            o_item.mode = hpd_pkg::MODE_POINT;
        end else if (i_order_u == hpd_pkg::ORDER_BITS'(1)) begin
            o_item.mode = hpd_pkg::MODE_DU1;
        end else begin
            o_item.mode = hpd_pkg::MODE_DUN;
        end
    end
endmodule

// ===== rtl/hpd_queue.sv =====
// Short item queue between front end and back end.
// Depends on hpd_pkg for the item type and depth.
module hpd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hpd_pkg::t_fitem i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output hpd_pkg::t_fitem o_item
);
    hpd_pkg::t_fitem                 r_mem [hpd_pkg::QDEPTH];
    logic [hpd_pkg::QPTR_W-1:0]      r_wr;
    logic [hpd_pkg::QPTR_W-1:0]      r_rd;
    logic [hpd_pkg::QCNT_W-1:0]      r_cnt;
    logic [hpd_pkg::QCNT_W-1:0]      n_cnt;

    assign o_full  = (r_cnt == hpd_pkg::QCNT_W'(hpd_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end
endmodule

// ===== rtl/hpd_sinq.sv =====
// Pipelined quarter-turn sine: Taylor series in Horner form, one stage group per term.
// Depends on hpd_pkg for constants and the constant-divisor tables.
module hpd_sinq (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [22:0] i_r,
    output logic [30:0] o_s
);
    logic [30:0] r_th1;
    logic [30:0] r_th2;
    logic [31:0] r_t2;
    logic [31:0] w_t  [hpd_pkg::NSTEP+1];
    logic [30:0] w_th [hpd_pkg::NSTEP+1];
    logic [30:0] w_h  [hpd_pkg::NSTEP+1];
    logic [61:0] r_pf;
    logic [30:0] r_s;
    logic [53:0] w_th_full;
    logic [61:0] w_t_full;

    assign w_th_full = 54'(i_r) * 54'(hpd_pkg::HALF_PI_Q30);
    assign w_t_full  = 62'(r_th1) * 62'(r_th1);
    assign w_t[0]  = r_t2;
    assign w_th[0] = r_th2;
    assign w_h[0]  = hpd_pkg::ONE_Q30;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_th1 <= w_th_full[52:22];
            r_th2 <= r_th1;
            r_t2  <= w_t_full[61:30];
        end
    end

    // each term: t*h, floor divide by reciprocal, correct, h = 1 - q
    for (genvar k = 0; k < hpd_pkg::NSTEP; k++) begin : g_step
        logic [62:0] r_p;
        logic [31:0] r_ta;
        logic [30:0] r_tha;
        logic [63:0] r_m;
        logic [31:0] r_x;
        logic [31:0] r_tb;
        logic [30:0] r_thb;
        logic [31:0] r_tc;
        logic [30:0] r_thc;
        logic [30:0] r_hc;
        logic [29:0] w_q0;
        logic [36:0] w_qd;
        logic [32:0] w_rem;
        logic [30:0] w_q;

        always_comb begin
            w_q0  = r_m[63:34];
            w_qd  = 37'(w_q0) * 37'(hpd_pkg::step_div(k));
            w_rem = {1'b0, r_x} - w_qd[32:0];
            w_q   = 31'(w_q0) + ((w_rem >= 33'(hpd_pkg::step_div(k))) ? 31'd1 : 31'd0);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p   <= 63'(w_t[k]) * 63'(w_h[k]);
                r_ta  <= w_t[k];
                r_tha <= w_th[k];
                r_m   <= 64'(r_p[61:30]) * 64'(hpd_pkg::step_mul(k));
                r_x   <= r_p[61:30];
                r_tb  <= r_ta;
                r_thb <= r_tha;
                r_hc  <= hpd_pkg::ONE_Q30 - w_q;
                r_tc  <= r_tb;
                r_thc <= r_thb;
            end
        end

        assign w_t[k+1]  = r_tc;
        assign w_th[k+1] = r_thc;
        assign w_h[k+1]  = r_hc;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pf  <= 62'(w_th[hpd_pkg::NSTEP]) * 62'(w_h[hpd_pkg::NSTEP]);
            r_s   <= (r_pf[61:30] > 32'(hpd_pkg::ONE_Q30)) ? hpd_pkg::ONE_Q30
                                                          : r_pf[60:30];
        end
    end

    assign o_s = r_s;
endmodule

// ===== rtl/hpd_back.sv =====
// Back end: sin/cos lanes, coefficient build, axis products, sum, round and clip.
// Depends on hpd_pkg, hpd_if and hpd_sinq.
module hpd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hpd_pkg::t_cfg   i_cfg,
    input  logic            i_head_valid,
    input  hpd_pkg::t_fitem i_head,
    output logic            o_pop,
    hpd_out_if.source       o_out
);
    localparam int LAT = hpd_pkg::SINQ_LAT;

    logic                 w_en;
    logic [30:0]          w_smag;
    logic [30:0]          w_cmag;
    hpd_pkg::t_side       w_side0;
    hpd_pkg::t_side       w_side1;
    logic                 r_vld  [LAT];
    hpd_pkg::t_side       r_side [LAT];
    logic signed [63:0]   r_pz;
    logic signed [63:0]   r_pd;
    logic signed [63:0]   w_czp;
    logic signed [63:0]   w_czd;

    logic                 r_v1, r_v2, r_v3, r_v4, r_v5;
    hpd_pkg::t_mode       r_mode1;
    logic signed [63:0]   r_pcx, r_pcy;
    logic signed [31:0]   r_cs, r_sn;
    logic signed [47:0]   r_cz1, r_cz2;
    logic signed [31:0]   w_cs, w_sn;
    logic signed [63:0]   w_rx, w_ry;
    logic signed [31:0]   w_dx, w_dy;
    logic signed [40:0]   w_cx, w_cy;
    logic signed [40:0]   r_cx, r_cy;
    logic                 r_co;

    logic signed [63:0]   r_po [3];
    logic signed [63:0]   r_px [3];
    logic signed [63:0]   r_py [3];
    logic signed [63:0]   r_pzz [3];
    logic signed [63:0]   r_a [3];
    logic signed [63:0]   r_b [3];
    logic signed [63:0]   r_acc [3];
    logic signed [63:0]   w_rs [3];
    logic signed [47:0]   w_res [3];
    logic [2:0]           w_clip;

    logic                 r_out_valid;
    logic signed [47:0]   r_res [3];
    logic                 r_sat;

    assign w_en  = !r_out_valid || o_out.ready;
    assign o_pop = w_en && i_head_valid;

    hpd_sinq u_sin (.i_clk(i_clk), .i_en(w_en), .i_r(i_head.rs), .o_s(w_smag));
    hpd_sinq u_cos (.i_clk(i_clk), .i_en(w_en), .i_r(i_head.rc), .o_s(w_cmag));

    always_comb begin
        w_side0.v     = i_head.v;
        w_side0.mode  = i_head.mode;
        w_side0.neg_s = i_head.neg_s;
        w_side0.neg_c = i_head.neg_c;
        w_side0.cz    = '0;

        w_czp = (r_pz + 64'sd32768) >>> 16;
        w_czd = (r_pd + 64'sd2097152) >>> 22;
        w_side1 = r_side[0];
        case (r_side[0].mode)
            hpd_pkg::MODE_POINT: w_side1.cz = w_czp[47:0];
            hpd_pkg::MODE_DU1:   w_side1.cz = w_czd[47:0];
            default:             w_side1.cz = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= w_side0;
            r_pz      <= 64'(i_head.u) * 64'(i_cfg.pitch);
            r_pd      <= 64'(i_cfg.pitch) * 64'(hpd_pkg::INV_TWO_PI_Q30);
            r_side[1] <= w_side1;
            for (int k = 2; k < LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // sign by quadrant, then v*trig
    always_comb begin
        w_sn = r_side[LAT-1].neg_s ? -$signed({1'b0, w_smag}) : $signed({1'b0, w_smag});
        w_cs = r_side[LAT-1].neg_c ? -$signed({1'b0, w_cmag}) : $signed({1'b0, w_cmag});
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mode1 <= r_side[LAT-1].mode;
            r_cz1   <= r_side[LAT-1].cz;
            r_pcx   <= 64'(r_side[LAT-1].v) * 64'(w_cs);
            r_pcy   <= 64'(r_side[LAT-1].v) * 64'(w_sn);
            r_cs    <= w_cs;
            r_sn    <= w_sn;
        end
    end

    always_comb begin
        w_rx = (r_pcx + 64'sd2097152) >>> 22;
        w_ry = (r_pcy + 64'sd2097152) >>> 22;
        w_dx = (r_cs + 32'sd32) >>> 6;
        w_dy = (r_sn + 32'sd32) >>> 6;
        if (r_mode1 inside {hpd_pkg::MODE_POINT, hpd_pkg::MODE_DU1, hpd_pkg::MODE_DUN}) begin
            w_cx = w_rx[40:0];
            w_cy = w_ry[40:0];
        end else if (r_mode1 == hpd_pkg::MODE_DV1) begin
            w_cx = 41'(w_dx);
            w_cy = 41'(w_dy);
        end else begin
            w_cx = '0;
            w_cy = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cx  <= w_cx;
            r_cy  <= w_cy;
            r_cz2 <= r_cz1;
            r_co  <= (r_mode1 == hpd_pkg::MODE_POINT);
            for (int k = 0; k < 3; k++) begin
                r_po[k]  <= r_co ? (64'($signed(i_cfg.origin[k])) <<< 23) : 64'sd0;
                r_px[k]  <= 64'(r_cx) * 64'($signed(i_cfg.axis[0][16*k +: 16]));
                r_py[k]  <= 64'(r_cy) * 64'($signed(i_cfg.axis[1][16*k +: 16]));
                r_pzz[k] <= 64'(r_cz2) * 64'($signed(i_cfg.axis[2][16*k +: 16]));
                r_a[k]   <= r_po[k] + r_px[k];
                r_b[k]   <= r_py[k] + r_pzz[k];
                r_acc[k] <= r_a[k] + r_b[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_rs[k] = (r_acc[k] + 64'sd4194304) >>> 23;
            if (w_rs[k] > hpd_pkg::OUT_MAX) begin
                w_res[k]  = hpd_pkg::OUT_MAX[47:0];
                w_clip[k] = 1'b1;
            end else if (w_rs[k] < hpd_pkg::OUT_MIN) begin
                w_res[k]  = hpd_pkg::OUT_MIN[47:0];
                w_clip[k] = 1'b1;
            end else begin
                w_res[k]  = w_rs[k][47:0];
                w_clip[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res[0] <= w_res[0];
            r_res[1] <= w_res[1];
            r_res[2] <= w_res[2];
            r_sat    <= |w_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_head_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_v1        <= r_vld[LAT-1];
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_v5        <= r_v4;
            r_out_valid <= r_v5;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.res_x     = r_res[0];
    assign o_out.res_y     = r_res[1];
    assign o_out.res_z     = r_res[2];
    assign o_out.saturated = r_sat;

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_v5) && $stable(r_vld[LAT-1]))
        else $error("pipeline moved while stalled");
    a_pop_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_head_valid)
        else $error("pop from empty queue");
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_sat |->
            (r_res[0] == hpd_pkg::OUT_MAX[47:0]) || (r_res[0] == hpd_pkg::OUT_MIN[47:0]) ||
            (r_res[1] == hpd_pkg::OUT_MAX[47:0]) || (r_res[1] == hpd_pkg::OUT_MIN[47:0]) ||
            (r_res[2] == hpd_pkg::OUT_MAX[47:0]) || (r_res[2] == hpd_pkg::OUT_MIN[47:0]))
        else $error("saturated flag without clipped component");
endmodule
